// ===== hw/rtl/wst_pkg.sv =====
// Shared types, character constants and helpers for the word and string tokenizer.
`default_nettype none

package wst_pkg;

  typedef enum logic [5:0] {
    ModeIdle    = 6'b000001,
    ModeComment = 6'b000010,
    ModeWord    = 6'b000100,
    ModeString  = 6'b001000,
    ModeEscape  = 6'b010000,
    ModeHalted  = 6'b100000
  } mode_e;

  typedef enum logic [1:0] {
    EvByte       = 2'd0,
    EvTokenEnd   = 2'd1,
    EvEndOfInput = 2'd2,
    EvError      = 2'd3
  } event_e;

  typedef enum logic [1:0] {
    ErrBadWordChar     = 2'd0,
    ErrUnterminated    = 2'd1,
    ErrNewlineInString = 2'd2,
    ErrBadEscape       = 2'd3
  } error_e;

  localparam logic KindWord   = 1'b0;
  localparam logic KindString = 1'b1;

  localparam logic [7:0] ChSpace   = 8'h20;
  localparam logic [7:0] ChNewline = 8'h0A;
  localparam logic [7:0] ChBslash  = 8'h5C;
  localparam logic [7:0] ChQuote   = 8'h22;
  localparam logic [7:0] ChN       = 8'h6E;

  localparam int unsigned FifoDepth = 3;

  typedef struct packed {
    event_e     event_res;
    logic       token_kind;
    logic [7:0] out_byte;
    error_e     error_code;
    logic       last;
  } result_t;

  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } lex_out_t;

  function automatic result_t make_result(event_e ev, logic kind, logic [7:0] data,
                                          error_e err);
    result_t r;
    r.event_res  = ev;
    r.token_kind = kind;
    r.out_byte   = data;
    r.error_code = err;
    r.last       = 1'b0;
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/wst_lexer.sv =====
// Lexer state register and the decode of one input transaction into up to two results.
`default_nettype none

module wst_lexer (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [7:0]        in_byte_i,
  input  logic              is_end_i,
  output wst_pkg::lex_out_t results_o
);
  import wst_pkg::*;

  mode_e      mode_q, mode_d;
  logic [1:0] n;
  result_t    first, second;
  logic       is_ws;

  assign is_ws = (in_byte_i == ChSpace) || (in_byte_i == ChNewline);

  always_comb begin
    mode_d = mode_q;
    n      = 2'd0;
    first  = make_result(EvByte, KindWord, 8'h00, ErrBadWordChar);
    second = make_result(EvByte, KindWord, 8'h00, ErrBadWordChar);
    unique case (mode_q)
      ModeIdle: begin
        priority if (is_end_i) begin
          first = make_result(EvEndOfInput, KindWord, 8'h00, ErrBadWordChar);
          n     = 2'd1;
        end else if (is_ws) begin
          mode_d = ModeIdle;
        end else if (in_byte_i == ChBslash) begin
          mode_d = ModeComment;
        end else if (in_byte_i == ChQuote) begin
          first  = make_result(EvByte, KindString, in_byte_i, ErrBadWordChar);
          n      = 2'd1;
          mode_d = ModeString;
        end else begin
          first  = make_result(EvByte, KindWord, in_byte_i, ErrBadWordChar);
          n      = 2'd1;
          mode_d = ModeWord;
        end
      end
      ModeComment: begin
        priority if (is_end_i) begin
          first  = make_result(EvEndOfInput, KindWord, 8'h00, ErrBadWordChar);
          n      = 2'd1;
          mode_d = ModeIdle;
        end else if (in_byte_i == ChNewline) begin
          mode_d = ModeIdle;
        end else begin
          mode_d = ModeComment;
        end
      end
      ModeWord: begin
        priority if (is_end_i) begin
          first  = make_result(EvTokenEnd, KindWord, 8'h00, ErrBadWordChar);
          second = make_result(EvEndOfInput, KindWord, 8'h00, ErrBadWordChar);
          n      = 2'd2;
          mode_d = ModeIdle;
        end else if (is_ws) begin
          first  = make_result(EvTokenEnd, KindWord, 8'h00, ErrBadWordChar);
          n      = 2'd1;
          mode_d = ModeIdle;
        end else if ((in_byte_i == ChBslash) || (in_byte_i == ChQuote)) begin
          first  = make_result(EvError, KindWord, 8'h00, ErrBadWordChar);
          n      = 2'd1;
          mode_d = ModeHalted;
        end else begin
          first = make_result(EvByte, KindWord, in_byte_i, ErrBadWordChar);
          n     = 2'd1;
        end
      end
      ModeString: begin
        priority if (is_end_i) begin
          first  = make_result(EvError, KindString, 8'h00, ErrUnterminated);
          n      = 2'd1;
          mode_d = ModeHalted;
        end else if (in_byte_i == ChNewline) begin
          first  = make_result(EvError, KindString, 8'h00, ErrNewlineInString);
          n      = 2'd1;
          mode_d = ModeHalted;
        end else if (in_byte_i == ChQuote) begin
          first  = make_result(EvTokenEnd, KindString, 8'h00, ErrBadWordChar);
          n      = 2'd1;
          mode_d = ModeIdle;
        end else if (in_byte_i == ChBslash) begin
          mode_d = ModeEscape;
        end else begin
          first = make_result(EvByte, KindString, in_byte_i, ErrBadWordChar);
          n     = 2'd1;
        end
      end
      ModeEscape: begin
        priority if (!is_end_i && (in_byte_i == ChBslash)) begin
          first  = make_result(EvByte, KindString, ChBslash, ErrBadWordChar);
          n      = 2'd1;
          mode_d = ModeString;
        end else if (!is_end_i && (in_byte_i == ChN)) begin
          first  = make_result(EvByte, KindString, ChNewline, ErrBadWordChar);
          n      = 2'd1;
          mode_d = ModeString;
        end else begin
          first  = make_result(EvError, KindString, 8'h00, ErrBadEscape);
          n      = 2'd1;
          mode_d = ModeHalted;
        end
      end
      ModeHalted: begin
        mode_d = ModeHalted;
      end
      default: begin
        mode_d = ModeHalted;
      end
    endcase
    first.last  = (n == 2'd1);
    second.last = (n == 2'd2);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeIdle;
    end else if (accept_i) begin
      mode_q <= mode_d;
    end
  end

  assign results_o.count  = accept_i ? n : 2'd0;
  assign results_o.first  = first;
  assign results_o.second = second;

endmodule

`default_nettype wire

// ===== hw/rtl/wst_result_fifo.sv =====
// Three-entry shifting result queue that takes up to two results per cycle.
`default_nettype none

module wst_result_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  wst_pkg::lex_out_t push_i,
  input  logic              pop_i,
  output wst_pkg::result_t  head_o,
  output logic              valid_o,
  output logic              room_o
);
  import wst_pkg::*;

  result_t    entries_q [FifoDepth];
  result_t    entries_d [FifoDepth];
  logic [1:0] count_q, count_d;
  logic [1:0] base;
  logic [1:0] base_next;

  assign base      = count_q - {1'b0, pop_i};
  assign base_next = base + 2'd1;

  always_comb begin
    for (int i = 0; i < FifoDepth; i++) begin
      entries_d[i] = entries_q[i];
    end
    if (pop_i) begin
      for (int i = 0; i < FifoDepth - 1; i++) begin
        entries_d[i] = entries_q[i + 1];
      end
    end
    if (push_i.count != 2'd0) begin
      entries_d[base] = push_i.first;
    end
    if (push_i.count == 2'd2) begin
      entries_d[base_next] = push_i.second;
    end
    count_d = base + push_i.count;
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < FifoDepth; i++) begin
      entries_q[i] <= entries_d[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 2'd0;
    end else begin
      count_q <= count_d;
    end
  end

  assign head_o  = entries_q[0];
  assign valid_o = (count_q != 2'd0);
  assign room_o  = (count_q <= 2'd1);

endmodule

`default_nettype wire

// ===== hw/rtl/word_and_string_tokenizer.sv =====
// Top level of the streaming word and string tokenizer.
// Each input transaction carries one source byte or an end-of-input mark and is decoded in
// the cycle it is accepted; its zero, one or two results enter a three-entry result queue
// and leave one per cycle while out_ready_i is high, the first in the cycle after the input
// transaction if the queue was empty. Input is taken in every cycle while the queue holds
// at most one result, so items that cause at most one result stream at one per cycle while
// the output keeps up; the single output port limits the rate to one result per cycle.
// After an error the block produces no further results until reset.
`default_nettype none

module word_and_string_tokenizer (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       is_end_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] event_res_o,
  output logic       token_kind_o,
  output logic [7:0] out_byte_o,
  output logic [1:0] error_code_o,
  output logic       last_o
);
  import wst_pkg::*;

  lex_out_t lex_results;
  result_t  head;
  logic     accept;
  logic     room;

  assign accept     = in_valid_i && room;
  assign in_ready_o = room;

  wst_lexer u_lexer (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .in_byte_i (in_byte_i),
    .is_end_i  (is_end_i),
    .results_o (lex_results)
  );

  wst_result_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (lex_results),
    .pop_i   (out_valid_o && out_ready_i),
    .head_o  (head),
    .valid_o (out_valid_o),
    .room_o  (room)
  );

  assign event_res_o  = head.event_res;
  assign token_kind_o = head.token_kind;
  assign out_byte_o   = head.out_byte;
  assign error_code_o = head.error_code;
  assign last_o       = head.last;

endmodule

`default_nettype wire

// ===== verif/word_and_string_tokenizer_tb.sv =====
// Self-checking testbench for the word and string tokenizer with a lexer scoreboard.
`timescale 1ns / 1ps

module word_and_string_tokenizer_tb;
  import wst_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam logic [8:0]  EndMark    = 9'h100;
  localparam error_e      NoError    = ErrBadWordChar;

  class lex_scoreboard;
    mode_e       mode;
    result_t     pending[$];
    int unsigned failures;

    function new();
      mode     = ModeIdle;
      failures = 0;
    endfunction

    function result_t lex_event(event_e ev, logic kind, logic [7:0] data, error_e err);
      result_t r;
      r.event_res  = ev;
      r.token_kind = kind;
      r.out_byte   = data;
      r.error_code = err;
      r.last       = 1'b0;
      return r;
    endfunction

    function void note_char(logic [7:0] c, logic at_end);
      result_t fresh[$];
      case (mode)
        ModeIdle: begin
          if (at_end) begin
            fresh.push_back(lex_event(EvEndOfInput, KindWord, 8'h00, NoError));
          end else if (c == ChBslash) begin
            mode = ModeComment;
          end else if (c == ChQuote) begin
            fresh.push_back(lex_event(EvByte, KindString, c, NoError));
            mode = ModeString;
          end else if (c != ChSpace && c != ChNewline) begin
            fresh.push_back(lex_event(EvByte, KindWord, c, NoError));
            mode = ModeWord;
          end
        end
        ModeComment: begin
          if (at_end) begin
            fresh.push_back(lex_event(EvEndOfInput, KindWord, 8'h00, NoError));
            mode = ModeIdle;
          end else if (c == ChNewline) begin
            mode = ModeIdle;
          end
        end
        ModeWord: begin
          if (at_end) begin
            fresh.push_back(lex_event(EvTokenEnd, KindWord, 8'h00, NoError));
            fresh.push_back(lex_event(EvEndOfInput, KindWord, 8'h00, NoError));
            mode = ModeIdle;
          end else if (c == ChSpace || c == ChNewline) begin
            fresh.push_back(lex_event(EvTokenEnd, KindWord, 8'h00, NoError));
            mode = ModeIdle;
          end else if (c == ChBslash || c == ChQuote) begin
            fresh.push_back(lex_event(EvError, KindWord, 8'h00, ErrBadWordChar));
            mode = ModeHalted;
          end else begin
            fresh.push_back(lex_event(EvByte, KindWord, c, NoError));
          end
        end
        ModeString: begin
          if (at_end) begin
            fresh.push_back(lex_event(EvError, KindString, 8'h00, ErrUnterminated));
            mode = ModeHalted;
          end else if (c == ChNewline) begin
            fresh.push_back(lex_event(EvError, KindString, 8'h00, ErrNewlineInString));
            mode = ModeHalted;
          end else if (c == ChQuote) begin
            fresh.push_back(lex_event(EvTokenEnd, KindString, 8'h00, NoError));
            mode = ModeIdle;
          end else if (c == ChBslash) begin
            mode = ModeEscape;
          end else begin
            fresh.push_back(lex_event(EvByte, KindString, c, NoError));
          end
        end
        ModeEscape: begin
          if (!at_end && c == ChBslash) begin
            fresh.push_back(lex_event(EvByte, KindString, ChBslash, NoError));
            mode = ModeString;
          end else if (!at_end && c == ChN) begin
            fresh.push_back(lex_event(EvByte, KindString, ChNewline, NoError));
            mode = ModeString;
          end else begin
            fresh.push_back(lex_event(EvError, KindString, 8'h00, ErrBadEscape));
            mode = ModeHalted;
          end
        end
        default: begin
          mode = ModeHalted;
        end
      endcase
      if (fresh.size() != 0) fresh[fresh.size() - 1].last = 1'b1;
      foreach (fresh[i]) pending.push_back(fresh[i]);
    endfunction

    function void check_event(result_t got);
      result_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result, expected none, got event %0d byte %h", $time,
                 got.event_res, got.out_byte);
        failures++;
        return;
      end
      want = pending.pop_front();
      if (got.event_res !== want.event_res) begin
        $display("%0t: event_res expected %0d, got %0d", $time, want.event_res,
                 got.event_res);
        failures++;
      end
      if (got.token_kind !== want.token_kind) begin
        $display("%0t: token_kind expected %0d, got %0d", $time, want.token_kind,
                 got.token_kind);
        failures++;
      end
      if (got.out_byte !== want.out_byte) begin
        $display("%0t: out_byte expected %h, got %h", $time, want.out_byte, got.out_byte);
        failures++;
      end
      if (got.error_code !== want.error_code) begin
        $display("%0t: error_code expected %0d, got %0d", $time, want.error_code,
                 got.error_code);
        failures++;
      end
      if (got.last !== want.last) begin
        $display("%0t: last expected %0d, got %0d", $time, want.last, got.last);
        failures++;
      end
    endfunction
  endclass

  logic       clk        = 1'b0;
  logic       rst_n      = 1'b0;
  logic       in_valid   = 1'b0;
  logic       in_ready;
  logic [7:0] in_byte    = 8'h00;
  logic       is_end     = 1'b0;
  logic       out_valid;
  logic       out_ready  = 1'b0;
  logic [1:0] event_res;
  logic       token_kind;
  logic [7:0] out_byte;
  logic [1:0] error_code;
  logic       res_last;

  int unsigned   send_idle_pct = 20;
  int unsigned   recv_idle_pct = 84;
  int unsigned   items_sent    = 0;
  int unsigned   cycle_count   = 0;
  lex_scoreboard sb            = new();

  word_and_string_tokenizer dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .in_byte_i    (in_byte),
    .is_end_i     (is_end),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .event_res_o  (event_res),
    .token_kind_o (token_kind),
    .out_byte_o   (out_byte),
    .error_code_o (error_code),
    .last_o       (res_last)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("word_and_string_tokenizer verification failed");
      $finish;
    end
  end

  // Each accepted transaction on either channel is handed to the scoreboard.
  always @(posedge clk) begin : monitor
    result_t got;
    got = result_t'({event_res, token_kind, out_byte, error_code, res_last});
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_char(in_byte, is_end);
      if (out_valid && out_ready) sb.check_event(got);
    end
  end

  function automatic logic [7:0] word_char();
    logic [7:0] c;
    do c = 8'($urandom_range(255));
    while (c == ChSpace || c == ChNewline || c == ChBslash || c == ChQuote);
    return c;
  endfunction

  function automatic logic [7:0] string_char();
    logic [7:0] c;
    do c = 8'($urandom_range(255));
    while (c == ChNewline || c == ChBslash || c == ChQuote);
    return c;
  endfunction

  function automatic logic [7:0] comment_char();
    logic [7:0] c;
    do c = 8'($urandom_range(255));
    while (c == ChNewline);
    return c;
  endfunction

  task automatic send_char(input logic [7:0] c, input logic at_end);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= c;
    is_end   <= at_end;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_end();
    send_char(8'($urandom_range(255)), 1'b1);
  endtask

  task automatic send_fragment();
    int unsigned pick;
    pick = $urandom_range(9);
    if (pick <= 3) begin
      repeat ($urandom_range(1, 6)) send_char(word_char(), 1'b0);
      pick = $urandom_range(9);
      if (pick < 5) send_char(ChSpace, 1'b0);
      else if (pick < 9) send_char(ChNewline, 1'b0);
      else send_end();
    end else if (pick <= 6) begin
      send_char(ChQuote, 1'b0);
      repeat ($urandom_range(0, 6)) begin
        if ($urandom_range(3) == 0) begin
          send_char(ChBslash, 1'b0);
          send_char($urandom_range(1) ? ChBslash : ChN, 1'b0);
        end else begin
          send_char(string_char(), 1'b0);
        end
      end
      send_char(ChQuote, 1'b0);
    end else if (pick == 7) begin
      send_char(ChBslash, 1'b0);
      repeat ($urandom_range(0, 5)) send_char(comment_char(), 1'b0);
      if ($urandom_range(3) == 0) send_end();
      else send_char(ChNewline, 1'b0);
    end else if (pick == 8) begin
      repeat ($urandom_range(1, 3)) send_char($urandom_range(1) ? ChSpace : ChNewline, 1'b0);
    end else begin
      send_end();
    end
  endtask

  task automatic send_error_tail();
    error_e     kind;
    logic [7:0] c;
    kind = error_e'(2'($urandom_range(3)));
    case (kind)
      ErrBadWordChar: begin
        send_char(word_char(), 1'b0);
        send_char($urandom_range(1) ? ChBslash : ChQuote, 1'b0);
      end
      ErrUnterminated: begin
        send_char(ChQuote, 1'b0);
        send_char(string_char(), 1'b0);
        send_end();
      end
      ErrNewlineInString: begin
        send_char(ChQuote, 1'b0);
        send_char(string_char(), 1'b0);
        send_char(ChNewline, 1'b0);
      end
      default: begin
        send_char(ChQuote, 1'b0);
        send_char(ChBslash, 1'b0);
        if ($urandom_range(1) == 0) begin
          send_end();
        end else begin
          do c = 8'($urandom_range(255));
          while (c == ChBslash || c == ChN);
          send_char(c, 1'b0);
        end
      end
    endcase
    repeat ($urandom_range(4, 10)) begin
      if ($urandom_range(3) == 0) send_end();
      else send_char(8'($urandom_range(255)), 1'b0);
    end
  endtask

  initial begin
    logic [8:0] directed_q[$];
    directed_q = '{EndMark, {1'b0, ChSpace}, {1'b0, ChNewline}, 9'h000, 9'h0FF,
                   {1'b0, ChSpace}, 9'h061, {1'b0, ChNewline}, {1'b0, ChBslash},
                   {1'b0, ChQuote}, {1'b0, ChNewline}, {1'b0, ChBslash}, EndMark,
                   {1'b0, ChQuote}, 9'h041, {1'b0, ChSpace}, {1'b0, ChBslash},
                   {1'b0, ChBslash}, {1'b0, ChBslash}, {1'b0, ChN}, 9'h0FF,
                   {1'b0, ChQuote}, {1'b0, ChN}, EndMark, EndMark};
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_q[i]) send_char(directed_q[i][7:0], directed_q[i][8]);
    while (items_sent < 200) send_fragment();
    send_idle_pct = 84;
    recv_idle_pct = 20;
    while (items_sent < 400) send_fragment();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    while (items_sent < 600) send_fragment();
    send_error_tail();
    in_valid <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (sb.failures == 0) begin
      $display("word_and_string_tokenizer verification clean");
    end else begin
      $display("word_and_string_tokenizer verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/wst_pkg.sv
hw/rtl/wst_lexer.sv
hw/rtl/wst_result_fifo.sv
hw/rtl/word_and_string_tokenizer.sv
verif/word_and_string_tokenizer_tb.sv
